// File: hw/rtl/ccw_pkg.sv
package ccw_pkg;

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [7:0]  PAD_BYTE = 8'hFF;
    localparam int unsigned CMD_FIFO_DEPTH = 2;

    // Row i holds the input bits whose parity gives output bit i of one
    // 32-bit word step of the CRC.
    typedef logic [31:0][31:0] t_crc_mat;

    // Command passed from the packing front end to the CRC engine.
    typedef struct packed {
        logic        has_word;
        logic        last;
        logic        seen;
        logic [31:0] word;
        logic [31:0] expected;
    } t_cmd;

    function automatic t_crc_mat f_crc_masks();
        t_crc_mat    m;
        logic [31:0] v;
        m = '0;
        for (int j = 0; j < 32; j++) begin
            v = 32'd1 << j;
            for (int b = 0; b < 32; b++) begin
                v = v[31] ? ((v << 1) ^ CRC_POLY) : (v << 1);
            end
            for (int i = 0; i < 32; i++) begin
                m[i][j] = v[i];
            end
        end
        return m;
    endfunction

endpackage

// File: hw/rtl/ccw_if.sv
interface ccw_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last_item;
    logic [31:0] expected_crc;

    modport source (output valid, output data_byte, output has_byte, output last_item,
                    output expected_crc, input ready);
    modport sink (input valid, input data_byte, input has_byte, input last_item,
                  input expected_crc, output ready);
endinterface

interface ccw_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] crc_value;
    logic        crc_match;

    modport source (output valid, output crc_value, output crc_match, input ready);
    modport sink (input valid, input crc_value, input crc_match, output ready);
endinterface

// File: hw/rtl/ccw_front.sv
module ccw_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ccw_in_if.sink        i_in,
    input  logic          i_cmd_full,
    output logic          o_cmd_push,
    output ccw_pkg::t_cmd o_cmd
);

    logic [23:0] r_partial, n_partial;
    logic [1:0]  r_phase, n_phase;
    logic        r_seen, n_seen;
    logic        accept;
    logic        word_full;
    logic [31:0] word;

    assign i_in.ready = !i_cmd_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_partial = r_partial;
        n_phase   = r_phase;
        n_seen    = r_seen;
        word_full = 1'b0;
        word      = {i_in.data_byte, r_partial};
        if (i_in.has_byte) begin
            n_seen = 1'b1;
            unique case (r_phase)
                2'd0: begin
                    n_partial = {16'd0, i_in.data_byte};
                    n_phase   = 2'd1;
                end
                2'd1: begin
                    n_partial = {8'd0, i_in.data_byte, r_partial[7:0]};
                    n_phase   = 2'd2;
                end
                2'd2: begin
                    n_partial = {i_in.data_byte, r_partial[15:0]};
                    n_phase   = 2'd3;
                end
                default: begin
                    word_full = 1'b1;
                    n_partial = '0;
                    n_phase   = 2'd0;
                end
            endcase
        end
        // A trailing partial word is closed with pad bytes on the last item.
        if (i_in.last_item && !word_full) begin
            unique case (n_phase)
                2'd1:    word = {{3{ccw_pkg::PAD_BYTE}}, n_partial[7:0]};
                2'd2:    word = {{2{ccw_pkg::PAD_BYTE}}, n_partial[15:0]};
                2'd3:    word = {ccw_pkg::PAD_BYTE, n_partial};
                default: word = {ccw_pkg::PAD_BYTE, n_partial};
            endcase
        end
    end

    always_comb begin
        o_cmd.has_word = word_full || (i_in.last_item && (n_phase != 2'd0));
        o_cmd.last     = i_in.last_item;
        o_cmd.seen     = n_seen;
        o_cmd.word     = word;
        o_cmd.expected = i_in.expected_crc;
        o_cmd_push     = accept && (o_cmd.has_word || i_in.last_item);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_phase   <= 2'd0;
            r_seen    <= 1'b0;
        end else if (accept) begin
            if (i_in.last_item) begin
                r_partial <= '0;
                r_phase   <= 2'd0;
                r_seen    <= 1'b0;
            end else begin
                r_partial <= n_partial;
                r_phase   <= n_phase;
                r_seen    <= n_seen;
            end
        end
    end

    a_phase_needs_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> (r_phase == 2'd0 && r_partial == '0))
        else $error("bytes pending without any byte seen");

endmodule

// File: hw/rtl/ccw_cmd_fifo.sv
module ccw_cmd_fifo #(
    parameter int unsigned DEPTH = ccw_pkg::CMD_FIFO_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ccw_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output ccw_pkg::t_cmd o_cmd
);

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    ccw_pkg::t_cmd   r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == FullCnt);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("command pushed into a full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FullCnt)
        else $error("command queue count out of range");

endmodule

// File: hw/rtl/ccw_back.sv
module ccw_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  ccw_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    ccw_out_if.source     o_out
);

    localparam ccw_pkg::t_crc_mat CrcMasks = ccw_pkg::f_crc_masks();

    logic [31:0] r_crc;
    logic        r_out_valid;
    logic [31:0] r_value;
    logic        r_match;
    logic        slot_free;
    logic [31:0] crc_in;
    logic [31:0] crc_step;
    logic [31:0] crc_next;
    logic [31:0] result;

    // One word step of the CRC is a fixed parity network per output bit.
    always_comb begin
        crc_in = r_crc ^ i_cmd.word;
        for (int i = 0; i < 32; i++) begin
            crc_step[i] = ^(crc_in & CrcMasks[i]);
        end
    end

    assign crc_next  = i_cmd.has_word ? crc_step : r_crc;
    assign result    = i_cmd.seen ? crc_next : 32'd0;
    assign slot_free = !r_out_valid || o_out.ready;
    assign o_cmd_pop = i_cmd_valid && (!i_cmd.last || slot_free);

    assign o_out.valid     = r_out_valid;
    assign o_out.crc_value = r_value;
    assign o_out.crc_match = r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= ccw_pkg::CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd_pop) begin
                r_crc <= i_cmd.last ? ccw_pkg::CRC_INIT : crc_next;
            end
            if (o_cmd_pop && i_cmd.last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.last) begin
            r_value <= result;
            r_match <= (result == i_cmd.expected);
        end
    end

    a_crc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && i_cmd.last) |=> (r_crc == ccw_pkg::CRC_INIT && r_out_valid))
        else $error("CRC not restarted after end of message");

    a_empty_message: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && i_cmd.last && !i_cmd.seen) |=> (r_value == 32'd0))
        else $error("empty message gave a nonzero CRC");

endmodule

// File: hw/rtl/crc32_word_checker_ff_pad.sv
// Transaction   Direction  Payload
// i_in          sink       data_byte[7:0], has_byte, last_item, expected_crc[31:0]
// o_out         source     crc_value[31:0], crc_match
//
// One byte is accepted per cycle while the command queue is not full; the result
// of a message goes through the command queue and the output register after its
// last transaction. The word CRC is a combinational parity network, so the engine
// drains one command per cycle unless o_out stalls; only a stall fills the queue.
// i_rst_n is synchronous and active low; it empties the queue and the output.
// A stall on o_out holds the last command in the queue; byte packing goes on
// until the queue is full, then i_in.ready drops.
module crc32_word_checker_ff_pad #(
    parameter int unsigned CMD_FIFO_DEPTH = ccw_pkg::CMD_FIFO_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ccw_in_if.sink    i_in,
    ccw_out_if.source o_out
);

    ccw_pkg::t_cmd push_cmd;
    ccw_pkg::t_cmd pop_cmd;
    logic          cmd_push;
    logic          cmd_full;
    logic          cmd_valid;
    logic          cmd_pop;

    ccw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd      (push_cmd)
    );

    ccw_cmd_fifo #(
        .DEPTH (CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (push_cmd),
        .o_full  (cmd_full),
        .o_valid (cmd_valid),
        .i_pop   (cmd_pop),
        .o_cmd   (pop_cmd)
    );

    ccw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (pop_cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );

endmodule

// File: sim/ccw_crc_checker.sv
`timescale 1ns / 1ps

module ccw_crc_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ccw_in_if    i_in_mon,
    ccw_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    typedef struct packed {
        logic [31:0] crc_value;
        logic        crc_match;
    } t_crc_result;

    logic [31:0] run_crc;
    logic [23:0] held_bytes;
    logic [1:0]  held_cnt;
    logic        msg_has_data;
    t_crc_result crc_expect_q[$];
    int          mismatch_cnt;
    int          checked_cnt;

    // One 32-bit word through the CRC, MSB first.
    function automatic logic [31:0] crc_fold_word(input logic [31:0] crc,
                                                  input logic [31:0] word);
        logic [31:0] c;
        c = crc ^ word;
        for (int b = 0; b < 32; b++) begin
            c = c[31] ? ((c << 1) ^ ccw_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic void note_mismatch(input string what, input t_crc_result want,
                                          input t_crc_result got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%0t: %s: expected crc %08h match %0b, got crc %08h match %0b",
                     $realtime, what, want.crc_value, want.crc_match,
                     got.crc_value, got.crc_match);
        end
    endfunction

    always @(posedge i_clk) begin
        t_crc_result want;
        t_crc_result got;
        logic [31:0] pad_word;
        logic [31:0] crc_out;
        if (!i_rst_n) begin
            run_crc      = ccw_pkg::CRC_INIT;
            held_bytes   = '0;
            held_cnt     = '0;
            msg_has_data = 1'b0;
            crc_expect_q.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (i_in_mon.has_byte) begin
                    msg_has_data = 1'b1;
                    if (held_cnt == 2'd3) begin
                        run_crc    = crc_fold_word(run_crc, {i_in_mon.data_byte, held_bytes});
                        held_bytes = '0;
                        held_cnt   = '0;
                    end else begin
                        held_bytes = held_bytes | (24'(i_in_mon.data_byte) << (8 * held_cnt));
                        held_cnt   = held_cnt + 2'd1;
                    end
                end
                if (i_in_mon.last_item) begin
                    // The unused upper byte lanes of a partial word are filled with pad bytes.
                    if (held_cnt != 2'd0) begin
                        pad_word = {8'h00, held_bytes} |
                                   ({4{ccw_pkg::PAD_BYTE}} << (8 * held_cnt));
                        run_crc  = crc_fold_word(run_crc, pad_word);
                    end
                    crc_out        = msg_has_data ? run_crc : 32'h0;
                    want.crc_value = crc_out;
                    want.crc_match = (crc_out == i_in_mon.expected_crc);
                    crc_expect_q.push_back(want);
                    run_crc      = ccw_pkg::CRC_INIT;
                    held_bytes   = '0;
                    held_cnt     = '0;
                    msg_has_data = 1'b0;
                end
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                got.crc_value = i_out_mon.crc_value;
                got.crc_match = i_out_mon.crc_match;
                if (crc_expect_q.size() == 0) begin
                    note_mismatch("result with no message pending", '0, got);
                end else begin
                    want = crc_expect_q.pop_front();
                    checked_cnt++;
                    if (got.crc_value !== want.crc_value || got.crc_match !== want.crc_match) begin
                        note_mismatch("result mismatch", want, got);
                    end
                end
            end
        end
        o_pending    <= crc_expect_q.size();
        o_fail_count <= mismatch_cnt;
        o_checked    <= checked_cnt;
    end

endmodule

// File: sim/crc32_word_checker_ff_pad_tb.sv
`timescale 1ns / 1ps

module crc32_word_checker_ff_pad_tb;

    localparam int STALL_LIMIT = 5000;

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   item_cnt;
    int   msg_cnt;
    int   stall_cycles;
    int   fail_count;
    int   pending;
    int   checked;
    logic [31:0] last_crc_seen;

    ccw_in_if  in_if ();
    ccw_out_if out_if ();

    crc32_word_checker_ff_pad dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    ccw_crc_checker crc_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_if),
        .i_out_mon    (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    wire in_acc  = in_if.valid && in_if.ready;
    wire out_acc = out_if.valid && out_if.ready;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || in_acc || out_acc) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (out_acc) begin
            last_crc_seen <= out_if.crc_value;
        end
    end

    initial begin
        @(posedge i_clk);
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    // Result receiver with random back-pressure.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic drive_item(input logic [7:0] d, input logic has, input logic last,
                              input logic [31:0] exp);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            in_if.valid        <= 1'b0;
            in_if.data_byte    <= 8'($urandom);
            in_if.has_byte     <= 1'($urandom);
            in_if.last_item    <= 1'($urandom);
            in_if.expected_crc <= $urandom;
            @(posedge i_clk);
        end
        in_if.valid        <= 1'b1;
        in_if.data_byte    <= d;
        in_if.has_byte     <= has;
        in_if.last_item    <= last;
        in_if.expected_crc <= exp;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (has || last) item_cnt++;
        if (last) msg_cnt++;
    endtask

    // Sends one message; split_end closes it with a separate empty last transaction.
    // noise_pct inserts ignored transactions that carry no byte.
    task automatic send_message(input logic [7:0] bytes[$], input bit split_end,
                                input logic [31:0] exp, input int noise_pct);
        bit close_on_byte;
        for (int i = 0; i < bytes.size(); i++) begin
            while (noise_pct != 0 && $urandom_range(99) < noise_pct) begin
                drive_item(8'($urandom), 1'b0, 1'b0, $urandom);
            end
            close_on_byte = !split_end && (i == bytes.size() - 1);
            drive_item(bytes[i], 1'b1, close_on_byte, close_on_byte ? exp : $urandom);
        end
        if (split_end || bytes.size() == 0) begin
            drive_item(8'($urandom), 1'b0, 1'b1, exp);
        end
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Sends a message, waits for its CRC, then sends it again expecting that CRC,
    // so the match flag is exercised on messages that should match.
    task automatic send_checked_pair(input logic [7:0] bytes[$], input bit split_end);
        send_message(bytes, split_end, $urandom, 0);
        drain_results();
        send_message(bytes, split_end, last_crc_seen, 0);
    endtask

    task automatic run_random(input int budget);
        logic [7:0]  bytes[$];
        logic [31:0] exp;
        int          stop_at;
        int          mode;
        int          len;
        stop_at = item_cnt + budget;
        while (item_cnt < stop_at) begin
            bytes = {};
            mode  = $urandom_range(99);
            len   = (mode < 5) ? 0 : (mode < 85) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            repeat (len) bytes.push_back(8'($urandom));
            mode = $urandom_range(99);
            exp  = (mode < 10) ? 32'h0 : (mode < 15) ? 32'hFFFF_FFFF : $urandom;
            if ($urandom_range(99) < 15) begin
                send_checked_pair(bytes, 1'($urandom_range(1)));
            end else begin
                send_message(bytes, ($urandom_range(3) == 0), exp, 8);
            end
        end
    endtask

    initial begin
        logic [7:0] bytes[$];
        i_rst_n            = 1'b0;
        in_if.valid        = 1'b0;
        in_if.data_byte    = '0;
        in_if.has_byte     = 1'b0;
        in_if.last_item    = 1'b0;
        in_if.expected_crc = '0;
        src_idle_pct       = 19;
        snk_idle_pct       = 51;
        item_cnt           = 0;
        msg_cnt            = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty messages, with and without a matching expected value.
        bytes = {};
        send_message(bytes, 1'b0, 32'h0, 0);
        send_message(bytes, 1'b0, 32'hFFFF_FFFF, 0);
        // Partial words of one, two and three bytes, ended on a byte and separately.
        bytes = {8'hFF};
        send_message(bytes, 1'b0, 32'h0, 0);
        bytes = {8'h00, 8'hFF};
        send_message(bytes, 1'b1, 32'hFFFF_FFFF, 0);
        bytes = {8'h00, 8'h00, 8'h00};
        send_message(bytes, 1'b0, 32'h0, 0);
        // A full word needs no padding; the second pass must report a match.
        bytes = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_checked_pair(bytes, 1'b0);
        // One word plus one padded byte, with ignored transactions mixed in.
        bytes = {8'hA5, 8'h00, 8'hFF, 8'h5A, 8'h3C};
        send_message(bytes, 1'b0, $urandom, 50);
        drain_results();

        run_random(500);
        src_idle_pct = 51;
        snk_idle_pct = 19;
        run_random(500);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(500);

        drain_results();
        repeat (10) @(posedge i_clk);
        $display("Checked %0d CRC results over %0d transactions in %0d messages,", checked,
                 item_cnt, msg_cnt);
        $display("covering empty, padded, full-word and matching messages under back-pressure.");
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
